/* design/knn_pkg.sv */
// Shared constants and types of the nearest-neighbour selection block.
package knn_pkg;

  localparam int MAX_NEIGHBORS = 16;
  localparam int NODE_W        = 10;
  localparam int DIST_W        = 32;
  localparam int CNT_W         = $clog2(MAX_NEIGHBORS + 1);
  localparam int Q_DEPTH       = 4;
  localparam int Q_PTR_W       = $clog2(Q_DEPTH);
  localparam int Q_CNT_W       = $clog2(Q_DEPTH + 1);
  localparam int CFG_ADDR_W    = 3;
  localparam int CFG_DATA_W    = 32;

  localparam logic [CFG_ADDR_W-1:0] REG_NEIGHBOR_COUNT = 3'd0;
  localparam logic [CNT_W-1:0]      NEIGHBOR_COUNT_RST = CNT_W'(MAX_NEIGHBORS);

  // One classified item as it waits between the front and the back.
  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic [DIST_W-1:0] distance;
    logic              keep;   // candidate differs from the query node
    logic              last;
  } knn_item_t;

  typedef struct packed {
    logic             emitting;
    logic [CNT_W-1:0] kept_count;
  } knn_status_t;

  typedef enum logic [1:0] {
    ST_RUN  = 2'b01,
    ST_EMIT = 2'b10
  } knn_state_t;

endpackage

/* design/knn_front.sv */
// Input side: takes items, flags self candidates and queues them for the back.
module knn_front import knn_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [NODE_W-1:0] in_query_node,
  input  logic [NODE_W-1:0] in_candidate_node,
  input  logic [DIST_W-1:0] in_candidate_distance,
  input  logic              in_last_candidate,
  output logic              q_valid,
  output knn_item_t         q_item,
  input  logic              q_pop
);

  knn_item_t            q_mem [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0]   q_cnt_r, q_cnt_nxt;
  logic                 push;
  knn_item_t            new_item;

  assign in_stall = (q_cnt_r == Q_CNT_W'(Q_DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (q_cnt_r != '0);
  assign q_item   = q_mem[rd_ptr_r];

  always_comb begin
    new_item.node     = in_candidate_node;
    new_item.distance = in_candidate_distance;
    new_item.keep     = (in_candidate_node != in_query_node);
    new_item.last     = in_last_candidate;
    wr_ptr_nxt        = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt        = q_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    q_cnt_nxt         = q_cnt_r + Q_CNT_W'(push) - Q_CNT_W'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      q_cnt_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      q_cnt_r  <= q_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= new_item;
    end
  end

endmodule

/* design/knn_back.sv */
// Back end: shift-insert sorted list of kept neighbours and the result drain.
module knn_back import knn_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [CNT_W-1:0]  neighbor_count,
  input  logic              q_valid,
  input  knn_item_t         q_item,
  output logic              q_pop,
  output knn_status_t       status,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [NODE_W-1:0] out_neighbor_index,
  output logic [DIST_W-1:0] out_neighbor_distance,
  output logic              out_last_neighbor
);

  knn_state_t          state_r, state_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [DIST_W-1:0]   dist_r [MAX_NEIGHBORS];
  logic [NODE_W-1:0]   idx_r  [MAX_NEIGHBORS];
  logic [DIST_W-1:0]   dist_nxt [MAX_NEIGHBORS];
  logic [NODE_W-1:0]   idx_nxt  [MAX_NEIGHBORS];
  logic [MAX_NEIGHBORS-1:0] move;
  logic [CNT_W-1:0]    k_eff, cnt_eff;
  logic                full, fits, do_ins, load_out, slots_we;
  logic                out_valid_r, out_valid_nxt;
  logic [NODE_W-1:0]   out_idx_r;
  logic [DIST_W-1:0]   out_dist_r;
  logic                out_last_r;

  assign q_pop     = (state_r == ST_RUN) && q_valid;
  assign load_out  = (state_r == ST_EMIT) && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_neighbor_index    = out_idx_r;
  assign out_neighbor_distance = out_dist_r;
  assign out_last_neighbor     = out_last_r;
  assign status.emitting   = (state_r == ST_EMIT);
  assign status.kept_count = cnt_r;

  // A lowered count trims the list to its nearest entries before each item.
  always_comb begin
    k_eff   = (neighbor_count > CNT_W'(MAX_NEIGHBORS)) ? CNT_W'(MAX_NEIGHBORS)
                                                         : neighbor_count;
    cnt_eff = (cnt_r > k_eff) ? k_eff : cnt_r;
    full    = (cnt_eff == k_eff);
    fits    = 1'b0;
    for (int i = 0; i < MAX_NEIGHBORS; i++) begin
      move[i] = (CNT_W'(i) >= cnt_eff) || (dist_r[i] > q_item.distance);
      if ((CNT_W'(i) < cnt_eff) && (dist_r[i] > q_item.distance)) begin
        fits = 1'b1;
      end
    end
    do_ins = q_pop && q_item.keep && (k_eff != '0) && (!full || fits);
  end

  // Slot i keeps its entry, takes the new item at the insertion point, or
  // takes its left neighbour; while draining, every slot but the last takes its right one.
  always_comb begin
    for (int i = 0; i < MAX_NEIGHBORS; i++) begin
      dist_nxt[i] = dist_r[i];
      idx_nxt[i]  = idx_r[i];
      if (load_out) begin
        if (i < MAX_NEIGHBORS - 1) begin
          dist_nxt[i] = dist_r[(i < MAX_NEIGHBORS - 1) ? i+1 : i];
          idx_nxt[i]  = idx_r[(i < MAX_NEIGHBORS - 1) ? i+1 : i];
        end
      end else if (move[i]) begin
        if (i == 0 || !move[(i == 0) ? 0 : i-1]) begin
          dist_nxt[i] = q_item.distance;
          idx_nxt[i]  = q_item.node;
        end else begin
          dist_nxt[i] = dist_r[(i == 0) ? 0 : i-1];
          idx_nxt[i]  = idx_r[(i == 0) ? 0 : i-1];
        end
      end
    end
    slots_we = do_ins || load_out;
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_RUN: begin
        if (q_pop) begin
          cnt_nxt = (do_ins && !full) ? cnt_eff + 1'b1 : cnt_eff;
          if (q_item.last && (cnt_nxt != '0)) begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (load_out) begin
          out_valid_nxt = 1'b1;
          cnt_nxt       = cnt_r - 1'b1;
          if (cnt_r == CNT_W'(1)) begin
            state_nxt = ST_RUN;
          end
        end
      end
      default: begin
        state_nxt = ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_RUN;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (slots_we) begin
      for (int i = 0; i < MAX_NEIGHBORS; i++) begin
        dist_r[i] <= dist_nxt[i];
        idx_r[i]  <= idx_nxt[i];
      end
    end
    if (load_out) begin
      out_idx_r  <= idx_r[0];
      out_dist_r <= dist_r[0];
      out_last_r <= (cnt_r == CNT_W'(1));
    end
  end

endmodule

/* design/k_nearest_neighbor_select_top.sv */
// Top level of the nearest-neighbour selection block: register port and wiring.
//
//  Channel  | Direction | Handshake       | Payload
//  ---------+-----------+-----------------+---------------------------------------------
//  in_      | input     | in_valid/stall  | query_node, candidate_node, distance, last
//  out_     | output    | out_valid/stall | neighbor_index, neighbor_distance, last
//  config   | input     | psel/penable    | neighbor_count at byte address 0
//
// The front takes one item per cycle into a four-entry queue unless it is full; the back
// inserts one queued item per cycle into its sorted list while not draining, so the
// sustained rate is one item per cycle outside a drain. A last item with n neighbours
// kept is followed by their drain, during which the back pulls nothing from the queue.
// Reset is synchronous and active low; it empties the queue and the list.
// in_stall rises only when the queue is full; out_stall holds the output register.
module k_nearest_neighbor_select_top import knn_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [NODE_W-1:0]     in_query_node,
  input  logic [NODE_W-1:0]     in_candidate_node,
  input  logic [DIST_W-1:0]     in_candidate_distance,
  input  logic                  in_last_candidate,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [NODE_W-1:0]     out_neighbor_index,
  output logic [DIST_W-1:0]     out_neighbor_distance,
  output logic                  out_last_neighbor,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [CNT_W-1:0] neighbor_count_r;
  logic             cfg_wr;
  logic             q_valid;
  logic             q_pop;
  knn_item_t        q_item;
  knn_status_t      status;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_NEIGHBOR_COUNT[2]);
  assign prdata = (paddr[2] == REG_NEIGHBOR_COUNT[2]) ?
                  CFG_DATA_W'(neighbor_count_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      neighbor_count_r <= NEIGHBOR_COUNT_RST;
    end else if (cfg_wr) begin
      neighbor_count_r <= pwdata[CNT_W-1:0];
    end
  end

  knn_front u_front (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_query_node         (in_query_node),
    .in_candidate_node     (in_candidate_node),
    .in_candidate_distance (in_candidate_distance),
    .in_last_candidate     (in_last_candidate),
    .q_valid               (q_valid),
    .q_item                (q_item),
    .q_pop                 (q_pop)
  );

  knn_back u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .neighbor_count        (neighbor_count_r),
    .q_valid               (q_valid),
    .q_item                (q_item),
    .q_pop                 (q_pop),
    .status                (status),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_neighbor_index    (out_neighbor_index),
    .out_neighbor_distance (out_neighbor_distance),
    .out_last_neighbor     (out_last_neighbor)
  );

  // The list never holds more entries than it has slots.
  assert property (@(posedge clk) disable iff (!rst_n)
    status.kept_count <= CNT_W'(MAX_NEIGHBORS))
    else $error("kept count exceeds list size");

  // No queued item is consumed while the list is being drained.
  assert property (@(posedge clk) disable iff (!rst_n)
    status.emitting |-> !q_pop)
    else $error("queue popped during drain");

  // A result appears only as a consequence of draining.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(status.emitting))
    else $error("result produced outside drain");

endmodule

/* tb/sv/tb_k_nearest_neighbor_select_top.sv */
// Self-checking testbench for the nearest-neighbour selection block.
`timescale 1ns / 100ps

module tb_k_nearest_neighbor_select_top import knn_pkg::*; ();

  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT   = 300000;
  localparam int RANDOM_ITEMS  = 125;

  typedef struct packed {
    logic [NODE_W-1:0] query;
    logic [NODE_W-1:0] node;
    logic [DIST_W-1:0] distance;
    logic              last;
  } candidate_t;

  typedef struct packed {
    logic [NODE_W-1:0] index;
    logic [DIST_W-1:0] distance;
    logic              last;
  } neighbor_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [NODE_W-1:0]     in_query_node;
  logic [NODE_W-1:0]     in_candidate_node;
  logic [DIST_W-1:0]     in_candidate_distance;
  logic                  in_last_candidate;
  logic                  out_valid;
  logic                  out_stall;
  logic [NODE_W-1:0]     out_neighbor_index;
  logic [DIST_W-1:0]     out_neighbor_distance;
  logic                  out_last_neighbor;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  // Own copy of the block's state, used to work out the expected neighbours.
  logic [CNT_W-1:0]  count_setting;
  logic [DIST_W-1:0] kept_dist [MAX_NEIGHBORS];
  logic [NODE_W-1:0] kept_node [MAX_NEIGHBORS];
  int                kept_total;

  neighbor_t expected_neighbors[$];
  int        mismatch_count;
  bit        calm;

  k_nearest_neighbor_select_top dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_query_node        (in_query_node),
    .in_candidate_node    (in_candidate_node),
    .in_candidate_distance(in_candidate_distance),
    .in_last_candidate    (in_last_candidate),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_neighbor_index   (out_neighbor_index),
    .out_neighbor_distance(out_neighbor_distance),
    .out_last_neighbor    (out_last_neighbor),
    .psel                 (psel),
    .penable              (penable),
    .pwrite               (pwrite),
    .paddr                (paddr),
    .pwdata               (pwdata),
    .prdata               (prdata),
    .pready               (pready)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic void flag_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%s", msg);
  endfunction

  // Sorted insertion of one candidate; the last item of a group releases the list.
  function automatic void select_nearest(input candidate_t c);
    int        limit;
    int        slot;
    int        tail;
    neighbor_t n;
    limit = (count_setting > MAX_NEIGHBORS) ? MAX_NEIGHBORS : int'(count_setting);
    if (kept_total > limit) kept_total = limit;
    if (c.node != c.query && limit > 0) begin
      slot = 0;
      while (slot < kept_total && kept_dist[slot] <= c.distance) slot++;
      if (kept_total < limit) begin
        tail = kept_total;
        kept_total++;
      end else begin
        tail = (slot < kept_total) ? kept_total - 1 : -1;
      end
      if (tail >= 0) begin
        for (int i = tail; i > slot; i--) begin
          kept_dist[i] = kept_dist[i-1];
          kept_node[i] = kept_node[i-1];
        end
        kept_dist[slot] = c.distance;
        kept_node[slot] = c.node;
      end
    end
    if (c.last) begin
      for (int i = 0; i < kept_total; i++) begin
        n.index    = kept_node[i];
        n.distance = kept_dist[i];
        n.last     = (i == kept_total - 1);
        expected_neighbors = {expected_neighbors, n};
      end
      kept_total = 0;
    end
  endfunction

  // Result checker: every accepted neighbour is matched against the oldest expectation.
  always @(posedge clk) begin
    neighbor_t got;
    neighbor_t exp_n;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_neighbor_index, out_neighbor_distance, out_last_neighbor};
      if (expected_neighbors.size() == 0) begin
        flag_mismatch($sformatf("unexpected neighbour: index %0d distance %h last %b",
                                got.index, got.distance, got.last));
      end else begin
        exp_n = expected_neighbors.pop_front();
        if (got.index !== exp_n.index || got.distance !== exp_n.distance ||
            got.last !== exp_n.last) begin
          flag_mismatch($sformatf(
            "neighbour mismatch: expected index %0d distance %h last %b, got %0d %h %b",
            exp_n.index, exp_n.distance, exp_n.last, got.index, got.distance, got.last));
        end
      end
    end
  end

  // Receiver back-pressure in short random bursts.
  always begin : out_stall_gen
    int n;
    @(posedge clk);
    if (!calm && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 3);
      out_stall <= 1'b1;
      repeat (n) @(posedge clk);
    end
    out_stall <= 1'b0;
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("status: fail");
    $finish;
  end

  // Writes the register, then reads it back over the same port.
  task automatic program_neighbor_count(input logic [CNT_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_NEIGHBOR_COUNT;
    pwdata  <= CFG_DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    count_setting = value;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== CFG_DATA_W'(value))
      flag_mismatch($sformatf("neighbor_count readback: expected %0d, got %0d", value, prdata));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Presents one candidate item and returns at the edge where it is accepted.
  task automatic send_candidate(input logic [NODE_W-1:0] query,
                                input logic [NODE_W-1:0] node,
                                input logic [DIST_W-1:0] distance,
                                input logic              last);
    candidate_t c;
    c = '{query, node, distance, last};
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid              <= 1'b1;
    in_query_node         <= query;
    in_candidate_node     <= node;
    in_candidate_distance <= distance;
    in_last_candidate     <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    select_nearest(c);
  endtask

  // Holds the sender back until every expected neighbour has come and the block is idle.
  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (expected_neighbors.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic test_field_extremes();
    // Count from reset: self candidate, ties at zero and the largest distance.
    send_candidate(10'd0, 10'd1023, 32'hFFFF_FFFF, 1'b0);
    send_candidate(10'd0, 10'd0, 32'h0000_0000, 1'b0);
    send_candidate(10'd0, 10'd5, 32'h0000_0000, 1'b0);
    send_candidate(10'd0, 10'd7, 32'h0000_0000, 1'b0);
    send_candidate(10'd0, 10'd1, 32'h8000_0000, 1'b1);
    wait_quiet();
  endtask

  task automatic test_full_list_ties();
    program_neighbor_count(5'd2);
    send_candidate(10'd1023, 10'd10, 32'd5, 1'b0);
    send_candidate(10'd1023, 10'd11, 32'd3, 1'b0);
    // Equal to the last kept distance on a full list, so it is dropped.
    send_candidate(10'd1023, 10'd12, 32'd5, 1'b0);
    send_candidate(10'd1023, 10'd13, 32'd4, 1'b0);
    // A self candidate that closes the group still releases the list.
    send_candidate(10'd1023, 10'd1023, 32'd0, 1'b1);
    wait_quiet();
  endtask

  task automatic test_count_extremes();
    program_neighbor_count(5'd0);
    send_candidate(10'd3, 10'd9, 32'd1, 1'b1);
    wait_quiet();
    program_neighbor_count(5'd31);
    send_candidate(10'd4, 10'd4, 32'd7, 1'b1);
    send_candidate(10'd4, 10'd6, 32'hFFFF_FFFF, 1'b0);
    send_candidate(10'd4, 10'd8, 32'h0001_0000, 1'b1);
    wait_quiet();
  endtask

  task automatic test_count_lowered_mid_group();
    send_candidate(10'd200, 10'd1, 32'd40, 1'b0);
    send_candidate(10'd200, 10'd2, 32'd10, 1'b0);
    send_candidate(10'd200, 10'd3, 32'd30, 1'b0);
    send_candidate(10'd200, 10'd4, 32'd20, 1'b0);
    wait_quiet();
    program_neighbor_count(5'd1);
    send_candidate(10'd200, 10'd5, 32'd25, 1'b1);
    wait_quiet();
  endtask

  task automatic test_query_changes();
    program_neighbor_count(5'd16);
    send_candidate(10'd10, 10'd20, 32'd2, 1'b0);
    send_candidate(10'd20, 10'd20, 32'd1, 1'b0);
    send_candidate(10'd30, 10'd10, 32'd3, 1'b1);
    wait_quiet();
  endtask

  function automatic logic [DIST_W-1:0] pick_distance();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2, 3:    return DIST_W'($urandom_range(0, 7));
      default: return DIST_W'($urandom);
    endcase
  endfunction

  function automatic logic [CNT_W-1:0] pick_count();
    case ($urandom_range(0, 11))
      0:       return 5'd0;
      1:       return 5'd1;
      2, 3:    return 5'd16;
      4:       return 5'd31;
      5:       return 5'd17;
      6:       return CNT_W'($urandom_range(18, 30));
      default: return CNT_W'($urandom_range(2, 8));
    endcase
  endfunction

  task automatic test_random_groups(input int total);
    int                sent;
    int                phase;
    int                group_len;
    logic [NODE_W-1:0] query;
    logic [NODE_W-1:0] node;
    sent  = 0;
    phase = 0;
    while (sent < total) begin
      // The register only changes once the block has drained completely.
      if (phase % 4 == 0) begin
        wait_quiet();
        program_neighbor_count(pick_count());
      end
      if (sent >= total - 30) calm = 1'b1;
      group_len = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 24) : $urandom_range(1, 6);
      query = NODE_W'($urandom_range(0, 1023));
      for (int i = 0; i < group_len; i++) begin
        if ($urandom_range(0, 19) == 0) query = NODE_W'($urandom_range(0, 1023));
        node = ($urandom_range(0, 7) == 0) ? query : NODE_W'($urandom_range(0, 1023));
        send_candidate(query, node, pick_distance(), i == group_len - 1);
      end
      sent += group_len;
      phase++;
    end
    wait_quiet();
  endtask

  initial begin
    rst_n                 <= 1'b0;
    in_valid              <= 1'b0;
    in_query_node         <= '0;
    in_candidate_node     <= '0;
    in_candidate_distance <= '0;
    in_last_candidate     <= 1'b0;
    out_stall             <= 1'b0;
    psel                  <= 1'b0;
    penable               <= 1'b0;
    pwrite                <= 1'b0;
    paddr                 <= '0;
    pwdata                <= '0;
    calm           = 1'b0;
    mismatch_count = 0;
    count_setting  = NEIGHBOR_COUNT_RST;
    kept_total     = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_field_extremes();
    test_full_list_ties();
    test_count_extremes();
    test_count_lowered_mid_group();
    test_query_changes();
    test_random_groups(RANDOM_ITEMS);

    if (mismatch_count == 0 && expected_neighbors.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
